// ===== rtl/core/mexp_pkg.sv =====
// Shared types, constants and microcode table of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int EXP_WIDTH  = 63;
    localparam int MOD_WIDTH  = 62;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
    localparam int PC_WIDTH   = 4;

    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

    typedef logic [PC_WIDTH-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_RED_STEP,
        OP_FIX_SIGN,
        OP_SETUP_ACC,
        OP_SETUP_SQR,
        OP_MUL_STEP,
        OP_STORE_ACC,
        OP_STORE_SQR,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_JUMP,
        COND_IN_IDLE,
        COND_M_ZERO,
        COND_CNT_RUN,
        COND_E_ZERO,
        COND_E_EVEN,
        COND_Y_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic m_zero;
        logic cnt_run;
        logic e_zero;
        logic e_even;
        logic y_more;
        logic out_busy;
    } status_t;

    // Program step addresses
    localparam pc_t STEP_IDLE      = pc_t'(0);
    localparam pc_t STEP_CHECK     = pc_t'(1);
    localparam pc_t STEP_REDUCE    = pc_t'(2);
    localparam pc_t STEP_FIX       = pc_t'(3);
    localparam pc_t STEP_ETEST     = pc_t'(4);
    localparam pc_t STEP_SETUP_ACC = pc_t'(5);
    localparam pc_t STEP_MUL_ACC   = pc_t'(6);
    localparam pc_t STEP_STORE_ACC = pc_t'(7);
    localparam pc_t STEP_SETUP_SQR = pc_t'(8);
    localparam pc_t STEP_MUL_SQR   = pc_t'(9);
    localparam pc_t STEP_STORE_SQR = pc_t'(10);
    localparam pc_t STEP_EMIT      = pc_t'(11);
    localparam pc_t STEP_DONE      = pc_t'(12);

    // Microcode: on a true condition go to target, otherwise fall through.
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:      w = '{OP_LOAD,      COND_IN_IDLE,  STEP_IDLE};
            STEP_CHECK:     w = '{OP_NOP,       COND_M_ZERO,   STEP_EMIT};
            STEP_REDUCE:    w = '{OP_RED_STEP,  COND_CNT_RUN,  STEP_REDUCE};
            STEP_FIX:       w = '{OP_FIX_SIGN,  COND_NEXT,     STEP_IDLE};
            STEP_ETEST:     w = '{OP_NOP,       COND_E_ZERO,   STEP_EMIT};
            STEP_SETUP_ACC: w = '{OP_SETUP_ACC, COND_E_EVEN,   STEP_SETUP_SQR};
            STEP_MUL_ACC:   w = '{OP_MUL_STEP,  COND_Y_MORE,   STEP_MUL_ACC};
            STEP_STORE_ACC: w = '{OP_STORE_ACC, COND_NEXT,     STEP_IDLE};
            STEP_SETUP_SQR: w = '{OP_SETUP_SQR, COND_NEXT,     STEP_IDLE};
            STEP_MUL_SQR:   w = '{OP_MUL_STEP,  COND_Y_MORE,   STEP_MUL_SQR};
            STEP_STORE_SQR: w = '{OP_STORE_SQR, COND_JUMP,     STEP_ETEST};
            STEP_EMIT:      w = '{OP_EMIT,      COND_OUT_BUSY, STEP_EMIT};
            STEP_DONE:      w = '{OP_NOP,       COND_JUMP,     STEP_IDLE};
            default:        w = '{OP_NOP,       COND_JUMP,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: sequencer plus datapath.
`timescale 1ns / 1ps

// Computes base^exponent mod modulus for a signed 64-bit base, an unsigned
// 63-bit exponent and a 62-bit modulus. Control is a 13-step microprogram
// held in a constant table; one control word per cycle drives a plain
// datapath of shift, add and compare-subtract units. The block works on one
// item at a time: s_ready is high only while the program sits at its idle
// step. After a transfer the base magnitude is reduced by a restoring
// remainder loop (one bit per cycle), the sign is folded in, and the
// exponent is scanned from its least significant bit. Each exponent bit
// costs a multiply of the accumulator (only when the bit is set) and a
// squaring; each modular multiply runs one shift-and-add step per
// multiplier bit up to its highest set bit (at most 62), plus setup and
// store. A zero modulus skips the work and returns 0. The result sits in
// an output register, so a finished result may wait on m_ready while the
// next item is already taken in.

module modular_exponentiation (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [mexp_pkg::DATA_WIDTH-1:0] s_base_value,
    input  logic [mexp_pkg::EXP_WIDTH-1:0]         s_exponent,
    input  logic [mexp_pkg::MOD_WIDTH-1:0]         s_modulus,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mexp_pkg::MOD_WIDTH-1:0]         m_power_residue
);

    mexp_pkg::uword_t  ctrl;
    mexp_pkg::status_t status;

    // Take a transfer only at the load step of the program
    assign s_ready = (ctrl.op == mexp_pkg::OP_LOAD);

    // Step counter and control table
    mexp_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Operand registers, arithmetic and output register
    mexp_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .s_valid         (s_valid),
        .s_base_value    (s_base_value),
        .s_exponent      (s_exponent),
        .s_modulus       (s_modulus),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_power_residue (m_power_residue),
        .status          (status)
    );

endmodule

// ===== rtl/core/mexp_sequencer.sv =====
// Microcode sequencer: step counter, control table lookup and branch logic.
`timescale 1ns / 1ps

module mexp_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  mexp_pkg::status_t status,
    output mexp_pkg::uword_t  ctrl
);

    mexp_pkg::pc_t pc_reg;
    mexp_pkg::pc_t pc_next;
    logic          taken;

    assign ctrl = mexp_pkg::ucode(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            mexp_pkg::COND_NEXT:     taken = 1'b0;
            mexp_pkg::COND_JUMP:     taken = 1'b1;
            mexp_pkg::COND_IN_IDLE:  taken = !status.in_valid;
            mexp_pkg::COND_M_ZERO:   taken = status.m_zero;
            mexp_pkg::COND_CNT_RUN:  taken = status.cnt_run;
            mexp_pkg::COND_E_ZERO:   taken = status.e_zero;
            mexp_pkg::COND_E_EVEN:   taken = status.e_even;
            mexp_pkg::COND_Y_MORE:   taken = status.y_more;
            mexp_pkg::COND_OUT_BUSY: taken = status.out_busy;
            default:                 taken = 1'b1;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + mexp_pkg::pc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mexp_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/mexp_datapath.sv =====
// Datapath: base reduction, shift-and-add modular multiply and result register.
`timescale 1ns / 1ps

module mexp_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mexp_pkg::uword_t                      ctrl,
    input  logic                                  s_valid,
    input  logic signed [mexp_pkg::DATA_WIDTH-1:0] s_base_value,
    input  logic [mexp_pkg::EXP_WIDTH-1:0]        s_exponent,
    input  logic [mexp_pkg::MOD_WIDTH-1:0]        s_modulus,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mexp_pkg::MOD_WIDTH-1:0]        m_power_residue,
    output mexp_pkg::status_t                     status
);

    localparam int DW = mexp_pkg::DATA_WIDTH;
    localparam int EW = mexp_pkg::EXP_WIDTH;
    localparam int MW = mexp_pkg::MOD_WIDTH;
    localparam int CW = mexp_pkg::CNT_WIDTH;

    logic [MW-1:0] m_reg,   m_next;
    logic [EW-1:0] e_reg,   e_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] b_reg,   b_next;
    logic [MW-1:0] x_reg,   x_next;
    logic [MW-1:0] y_reg,   y_next;
    logic [MW-1:0] p_reg,   p_next;
    logic [DW-1:0] q_reg,   q_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [MW-1:0] out_data_reg,  out_data_next;

    logic [DW-1:0] base_bits;
    logic [DW-1:0] base_mag;
    logic [MW:0]   red_trial;
    logic [MW:0]   mod_ext;
    logic [MW:0]   add_sum;
    logic [MW:0]   dbl_val;
    logic          out_busy;

    assign base_bits = s_base_value;
    assign base_mag  = base_bits[DW-1] ? (~base_bits + DW'(1)) : base_bits;
    assign mod_ext   = {1'b0, m_reg};
    assign red_trial = {b_reg, q_reg[DW-1]};
    assign add_sum   = {1'b0, p_reg} + {1'b0, x_reg};
    assign dbl_val   = {x_reg, 1'b0};
    assign out_busy  = out_valid_reg && !m_ready;

    assign status.in_valid = s_valid;
    assign status.m_zero   = (m_reg == '0);
    assign status.cnt_run  = (cnt_reg != mexp_pkg::CNT_LAST);
    assign status.e_zero   = (e_reg == '0);
    assign status.e_even   = !e_reg[0];
    assign status.y_more   = |y_reg[MW-1:1];
    assign status.out_busy = out_busy;

    assign m_valid         = out_valid_reg;
    assign m_power_residue = out_data_reg;

    always_comb begin
        m_next         = m_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (ctrl.op)
            mexp_pkg::OP_NOP: begin
            end
            mexp_pkg::OP_LOAD: begin
                if (s_valid) begin
                    m_next   = s_modulus;
                    e_next   = s_exponent;
                    q_next   = base_mag;
                    neg_next = base_bits[DW-1];
                    b_next   = '0;
                    cnt_next = '0;
                    // 1 mod m, which is 0 for a modulus of one (or zero)
                    acc_next = (s_modulus > MW'(1)) ? MW'(1) : '0;
                end
            end
            mexp_pkg::OP_RED_STEP: begin
                // one restoring remainder step per magnitude bit
                if (red_trial >= mod_ext) begin
                    b_next = MW'(red_trial - mod_ext);
                end else begin
                    b_next = MW'(red_trial);
                end
                q_next   = {q_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
            end
            mexp_pkg::OP_FIX_SIGN: begin
                if (neg_reg && (b_reg != '0)) begin
                    b_next = m_reg - b_reg;
                end
            end
            mexp_pkg::OP_SETUP_ACC: begin
                x_next = acc_reg;
                y_next = b_reg;
                p_next = '0;
            end
            mexp_pkg::OP_SETUP_SQR: begin
                x_next = b_reg;
                y_next = b_reg;
                p_next = '0;
            end
            mexp_pkg::OP_MUL_STEP: begin
                if (y_reg[0]) begin
                    p_next = (add_sum >= mod_ext) ? MW'(add_sum - mod_ext) : MW'(add_sum);
                end
                x_next = (dbl_val >= mod_ext) ? MW'(dbl_val - mod_ext) : MW'(dbl_val);
                y_next = {1'b0, y_reg[MW-1:1]};
            end
            mexp_pkg::OP_STORE_ACC: begin
                acc_next = p_reg;
            end
            mexp_pkg::OP_STORE_SQR: begin
                b_next = p_reg;
                e_next = {1'b0, e_reg[EW-1:1]};
            end
            mexp_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg        <= m_next;
        e_reg        <= e_next;
        acc_reg      <= acc_next;
        b_reg        <= b_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/mexp_checker.sv =====
// Port-level checks of the modular exponentiation block, bound to the top level.
`timescale 1ns / 1ps

module mexp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [mexp_pkg::MOD_WIDTH-1:0]  m_power_residue
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_residue))
        else $error("result changed or dropped while stalled");

    // One item at a time: s_ready is low again once an item has been taken
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken while an item is still at work");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A new result only shows up while an item is being finished, never at the load step
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready)
        else $error("result appeared while the block was open for input");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_power_residue (m_power_residue)
);

// ===== tb/modular_exponentiation_tb.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    localparam int DATA_WIDTH = mexp_pkg::DATA_WIDTH;
    localparam int EXP_WIDTH  = mexp_pkg::EXP_WIDTH;
    localparam int MOD_WIDTH  = mexp_pkg::MOD_WIDTH;

    // Run limit: far more than the worst-case items of the whole job list need.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_JOBS = 81;
    localparam int TAIL_JOBS   = 15;
    localparam int SETTLE      = 40;

    localparam logic [DATA_WIDTH-1:0] BASE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_WIDTH-1:0] BASE_MIN = 64'h8000_0000_0000_0000;
    localparam logic [EXP_WIDTH-1:0]  EXP_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [MOD_WIDTH-1:0]  MOD_MAX  = 62'h3FFF_FFFF_FFFF_FFFF;

    // One exponentiation request plus how the sender treats it.
    typedef struct {
        logic [DATA_WIDTH-1:0] base_bits;
        logic [EXP_WIDTH-1:0]  expo;
        logic [MOD_WIDTH-1:0]  modv;
        bit                    drain_first;  // wait for every result before sending
        int                    idle_pct;     // chance of an idle burst on either side
        bit                    tail;         // part of the quiet closing stretch
    } mexp_job_t;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [DATA_WIDTH-1:0]  s_base_value = '0;
    logic [EXP_WIDTH-1:0]          s_exponent   = '0;
    logic [MOD_WIDTH-1:0]          s_modulus    = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [MOD_WIDTH-1:0]          m_power_residue;

    mexp_job_t              job_q[$];
    logic [MOD_WIDTH-1:0]   pending_residues[$];
    int                     total_jobs   = 0;
    int                     accepted_cnt = 0;
    int                     mismatches   = 0;
    int                     cycle_cnt    = 0;
    int                     gap_left     = 0;
    int                     stall_left   = 0;
    int                     ready_idle_pct = 30;
    bit                     calm_tail    = 1'b0;

    modular_exponentiation u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base_value    (s_base_value),
        .s_exponent      (s_exponent),
        .s_modulus       (s_modulus),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_power_residue (m_power_residue)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Shift-and-add product x*y mod m; x, y below m, m below 2^62 so the
    // doubling never leaves 64 bits.
    function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        while (y != 0) begin
            if (y[0]) begin
                acc = acc + x;
                if (acc >= m) acc = acc - m;
            end
            x = x << 1;
            if (x >= m) x = x - m;
            y = y >> 1;
        end
        return acc;
    endfunction

    // base^expo mod modv, base read as two's complement; a zero modulus gives 0.
    function automatic logic [MOD_WIDTH-1:0] power_mod(logic [DATA_WIDTH-1:0] base_bits,
                                                       logic [EXP_WIDTH-1:0] expo,
                                                       logic [MOD_WIDTH-1:0] modv);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] e;
        logic [63:0] rem;
        m = 64'(modv);
        if (m == 0) return '0;
        acc = 64'd1 % m;
        // Fold the sign in: a negative base maps to m minus its magnitude's residue.
        if (base_bits[DATA_WIDTH-1]) begin
            rem = (-base_bits) % m;
            sq  = (rem == 0) ? 64'd0 : m - rem;
        end else begin
            sq = base_bits % m;
        end
        e = 64'(expo);
        while (e != 0) begin
            if (e[0]) acc = mod_product(acc, sq, m);
            sq = mod_product(sq, sq, m);
            e  = e >> 1;
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random value confined to its low n bits; n = 0 gives zero.
    function automatic logic [63:0] rand_bits(int n);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (n <= 0) return '0;
        if (n < 64) v = v & ((64'd1 << n) - 64'd1);
        return v;
    endfunction

    task automatic add_job(logic [DATA_WIDTH-1:0] b, logic [EXP_WIDTH-1:0] e,
                           logic [MOD_WIDTH-1:0] m, bit drain, int pct, bit tail);
        mexp_job_t job;
        job.base_bits   = b;
        job.expo        = e;
        job.modv        = m;
        job.drain_first = drain;
        job.idle_pct    = pct;
        job.tail        = tail;
        job_q.push_back(job);
        total_jobs++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one transfer per job, with idle bursts between transfers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        mexp_job_t job;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Record the prediction at the edge that completes the transfer.
            if (s_valid && s_ready) begin
                pending_residues.push_back(power_mod(s_base_value, s_exponent, s_modulus));
                accepted_cnt++;
            end
            // Hold valid and payload until the current item is taken.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (job_q.size() != 0 && job_q[0].drain_first &&
                             pending_residues.size() != 0) begin
                    // Hold off until the block has delivered everything owed.
                    s_valid <= 1'b0;
                end else if (job_q.size() != 0) begin
                    job = job_q.pop_front();
                    s_valid        <= 1'b1;
                    s_base_value   <= job.base_bits;
                    s_exponent     <= job.expo;
                    s_modulus      <= job.modv;
                    ready_idle_pct <= job.idle_pct;
                    calm_tail      <= job.tail;
                    if ($urandom_range(0, 99) < job.idle_pct)
                        gap_left = $urandom_range(1, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each result transfer, stall m_ready in bursts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [MOD_WIDTH-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_residues.size() == 0) begin
                    $error("power_residue: expected none, actual %0h", m_power_residue);
                    mismatches++;
                end else begin
                    want = pending_residues.pop_front();
                    if (m_power_residue !== want) begin
                        $error("power_residue: expected %0h, actual %0h",
                               want, m_power_residue);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 99) < ready_idle_pct) begin
                // Start a stall: m_ready drops now and stays low while stall_left counts down.
                stall_left = $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Job list, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [DATA_WIDTH-1:0] b;
        logic [EXP_WIDTH-1:0]  e;
        logic [MOD_WIDTH-1:0]  m;
        int                    len;
        int                    pick;
        bit                    tail;
        int                    pct;

        // Directed: trivial moduli, zero exponents, field extremes, sign handling.
        add_job(64'd0, 63'd0, 62'd1, 1'b0, 30, 1'b0);          // modulus of one
        add_job(64'd5, 63'd0, 62'd7, 1'b0, 30, 1'b0);          // zero exponent gives 1
        add_job(64'd0, 63'd0, 62'd5, 1'b0, 30, 1'b0);          // zero to the zero
        add_job(64'd0, 63'd3, 62'd5, 1'b0, 30, 1'b0);
        add_job(BASE_MAX, EXP_MAX, MOD_MAX, 1'b0, 30, 1'b0);
        add_job(BASE_MIN, EXP_MAX, MOD_MAX, 1'b0, 30, 1'b0);   // most negative base
        add_job(-64'sd1, 63'd1, MOD_MAX, 1'b0, 30, 1'b0);
        add_job(-64'sd1, EXP_MAX, 62'd1000003, 1'b0, 30, 1'b0);
        add_job(64'd12345, 63'd99, 62'd0, 1'b0, 30, 1'b0);     // zero modulus
        add_job(BASE_MIN, 63'd0, 62'd0, 1'b0, 30, 1'b0);       // zero modulus, zero exponent
        add_job(BASE_MAX, EXP_MAX, 62'd1, 1'b0, 30, 1'b0);
        add_job(64'd7, 63'd2, 62'd7, 1'b0, 30, 1'b0);          // base equal to modulus
        add_job(-64'sd21, 63'd3, 62'd7, 1'b1, 30, 1'b0);       // negative multiple of modulus
        add_job(-64'sd3, 63'd5, 62'h2000_0000_0000_0000, 1'b0, 30, 1'b0);
        add_job(64'd3, 63'h4000_0000_0000_0000, 62'h3FFF_FFFF_FFFF_FFC5, 1'b0, 30, 1'b0);
        add_job(64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                62'h2AAA_AAAA_AAAA_AAAB, 1'b0, 0, 1'b0);
        add_job(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                62'h1555_5555_5555_5555, 1'b0, 0, 1'b0);
        add_job(64'd2, 63'd61, 62'd2, 1'b0, 30, 1'b0);
        add_job(-64'sd5, 63'd2, 62'd3, 1'b0, 30, 1'b0);

        // Random: mostly short exponents, a few full width; phases with and
        // without idling, and a quiet closing stretch.
        for (int i = 0; i < RANDOM_JOBS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                b = rand_bits(64);
            end else begin
                b = 64'($urandom_range(0, 2000)) - 64'd1000;
            end

            pick = $urandom_range(0, 99);
            if (pick < 10)      e = EXP_WIDTH'(rand_bits(EXP_WIDTH));
            else if (pick < 20) e = EXP_WIDTH'(rand_bits($urandom_range(13, 40)));
            else                e = EXP_WIDTH'(rand_bits($urandom_range(0, 12)));

            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                m = '0;
            end else if (pick < 15) begin
                m = MOD_WIDTH'($urandom_range(1, 16));
            end else begin
                len = $urandom_range(1, MOD_WIDTH);
                m = MOD_WIDTH'(rand_bits(len) | (64'd1 << (len - 1)));
            end

            tail = (i >= RANDOM_JOBS - TAIL_JOBS);
            pct  = tail ? 0 : (((i / 15) % 2) != 0 ? 0 : 35);
            add_job(b, e, m, (i == 0 || i == 40 || i == 70), pct, tail);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < total_jobs) @(posedge aclk);
        while (pending_residues.size() != 0) @(posedge aclk);
        // Catch any stray result after the last one owed.
        repeat (SETTLE) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
